### sv/f2i24_pkg.sv
//------------------------------------------------------------------------------
// f2i24_pkg
// types and constants shared by the float32 to int24 packer
//------------------------------------------------------------------------------
`default_nettype none
package f2i24_pkg;

  localparam int unsigned FracBits = 40;
  localparam logic [7:0] ExpMax   = 8'd255;
  localparam logic [7:0] ExpUnity = 8'd127;
  localparam logic [7:0] ExpTiny  = 8'd87;
  localparam logic [23:0] PosFull = 24'h7FFFFF;
  localparam logic [23:0] NegFull = 24'h800000;

  typedef struct packed {
    logic [31:0] sample_bits;
    logic        last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_first;
    logic [7:0] byte_middle;
    logic [7:0] byte_final;
    logic       last_out;
  } out_item_t;

endpackage
`default_nettype wire

### sv/f2i24_convert.sv
//------------------------------------------------------------------------------
// f2i24_convert
// combinational float32 to saturated, rounded 24-bit two's complement word
//------------------------------------------------------------------------------
`default_nettype none
module f2i24_convert
  import f2i24_pkg::*;
(
  input  wire logic [31:0] sample_bits,
  output logic      [23:0] word
);

  logic        sign;
  logic [7:0]  expo;
  logic [22:0] frac;
  logic [5:0]  shamt;
  logic [63:0] q;
  logic [63:0] half;
  logic [24:0] pos_mag;
  logic [63:0] neg_sum;
  logic [24:0] neg_mag;

  assign sign  = sample_bits[31];
  assign expo  = sample_bits[30:23];
  assign frac  = sample_bits[22:0];
  assign shamt = 6'(expo - ExpTiny);
  assign q     = {40'd0, 1'b1, frac} << shamt;
  assign half  = 64'd1 << (FracBits - 1);
  assign pos_mag = 25'((q + half) >> FracBits);
  // round half toward +inf on the negative side: ceil((q - half) / 2^40)
  assign neg_sum = q - half + ((64'd1 << FracBits) - 64'd1);
  assign neg_mag = 25'(neg_sum >> FracBits);

  always_comb begin
    priority if (expo == ExpMax) begin
      word = (frac != '0 || !sign) ? PosFull : NegFull;
    end else if (expo < ExpTiny) begin
      word = '0;
    end else if (expo > ExpUnity) begin
      word = sign ? NegFull : PosFull;
    end else if (!sign) begin
      word = (pos_mag > 25'(PosFull)) ? PosFull : pos_mag[23:0];
    end else if (q <= half) begin
      word = '0;
    end else begin
      word = (neg_mag >= 25'h800000) ? NegFull : 24'(-neg_mag[23:0]);
    end
  end

endmodule
`default_nettype wire

### sv/float32_to_int24_packer_unit.sv
//------------------------------------------------------------------------------
// float32_to_int24_packer_unit
// float32 audio sample to three-byte signed 24-bit pcm word
//------------------------------------------------------------------------------
// One item is taken every clock (busy is always low); its result appears with
// done high after one input register and one result register. The receiver
// cannot stall, so results must be taken as they come. msb_first (reset 1)
// picks the byte order and should only be written while no item is in flight.
`default_nettype none
module float32_to_int24_packer_unit
  import f2i24_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_item,
  input  wire logic      cfg_we,
  input  wire logic      cfg_wdata,
  output logic           done,
  output out_item_t      out_item
);

  logic      msb_first;
  logic      in_valid;
  in_item_t  in_reg;
  logic [23:0] word;

  assign busy = 1'b0;

  f2i24_convert u_convert (
    .sample_bits (in_reg.sample_bits),
    .word        (word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      msb_first <= 1'b1;
      in_valid  <= 1'b0;
      done      <= 1'b0;
    end else begin
      if (cfg_we) msb_first <= cfg_wdata;
      in_valid <= start;
      done     <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start) in_reg <= in_item;
    if (in_valid) begin
      out_item.byte_first  <= msb_first ? word[23:16] : word[7:0];
      out_item.byte_middle <= word[15:8];
      out_item.byte_final  <= msb_first ? word[7:0] : word[23:16];
      out_item.last_out    <= in_reg.last_in;
    end
  end

endmodule
`default_nettype wire

### sv/f2i24_checker.sv
//------------------------------------------------------------------------------
// f2i24_checker
// port-level checks for the packer
//------------------------------------------------------------------------------
`default_nettype none
module f2i24_checker
  import f2i24_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      done,
  input wire out_item_t out_item
);

  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    $past(start, 2) && !$past(rst, 1) && !$past(rst, 2) |-> done)
    else $error("item lost");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 2))
    else $error("result without item");

  a_no_done_after_rst: assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("done right after reset");

endmodule

bind float32_to_int24_packer_unit f2i24_checker u_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .done(done), .out_item(out_item)
);
`default_nettype wire

### test/pcm24_checker.sv
//------------------------------------------------------------------------------
// pcm24_checker
// predicts the 24-bit pcm bytes of each accepted sample and compares them
//------------------------------------------------------------------------------
`default_nettype none
module pcm24_checker
  import f2i24_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire logic      busy,
  input  wire in_item_t  in_item,
  input  wire logic      cfg_we,
  input  wire logic      cfg_wdata,
  input  wire logic      done,
  input  wire out_item_t out_item,
  output int             fail_count,
  output int             pending
);

  logic      order_msb;
  out_item_t pcm_queue[$];

  // exact floor(x * 2^23 + 0.5) with saturation, as a 24-bit pattern
  function automatic logic [23:0] pcm_word(logic [31:0] bits);
    logic       sgn;
    logic [7:0] ex;
    logic [22:0] fr;
    logic [63:0] q;
    logic [63:0] half;
    logic [63:0] mag;
    sgn = bits[31];
    ex = bits[30:23];
    fr = bits[22:0];
    half = 64'd1 << (FracBits - 1);
    if (ex == ExpMax) begin
      if (fr != 0 || !sgn) return PosFull;
      return NegFull;
    end
    if (ex < ExpTiny) return 24'd0;
    if (ex > ExpUnity) return sgn ? NegFull : PosFull;
    q = {40'd0, 1'b1, fr} << (ex - ExpTiny);
    if (!sgn) begin
      mag = (q + half) >> FracBits;
      if (mag > 64'(PosFull)) mag = 64'(PosFull);
      return mag[23:0];
    end
    if (q <= half) return 24'd0;
    mag = (q - half + ((64'd1 << FracBits) - 1)) >> FracBits;
    if (mag > 64'(NegFull)) mag = 64'(NegFull);
    return 24'd0 - mag[23:0];
  endfunction

  always @(posedge clk) begin
    logic [23:0] w;
    out_item_t   exp_item;
    if (rst) begin
      order_msb <= 1'b1;
      pcm_queue.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) order_msb <= cfg_wdata;
      if (done) begin
        if (pcm_queue.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result %h", out_item);
        end else begin
          exp_item = pcm_queue.pop_front();
          if (exp_item !== out_item) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: expected %h %h %h %b got %h %h %h %b",
                       exp_item.byte_first, exp_item.byte_middle,
                       exp_item.byte_final, exp_item.last_out,
                       out_item.byte_first, out_item.byte_middle,
                       out_item.byte_final, out_item.last_out);
          end
        end
      end
      if (start && !busy) begin
        w = pcm_word(in_item.sample_bits);
        exp_item.byte_first  = order_msb ? w[23:16] : w[7:0];
        exp_item.byte_middle = w[15:8];
        exp_item.byte_final  = order_msb ? w[7:0] : w[23:16];
        exp_item.last_out    = in_item.last_in;
        pcm_queue.push_back(exp_item);
      end
      pending <= pcm_queue.size();
    end
  end

endmodule
`default_nettype wire

### test/tb.sv
//------------------------------------------------------------------------------
// tb
// drives float32 samples into the packer in bursts and gives the verdict
//------------------------------------------------------------------------------
`default_nettype none
module tb;
  import f2i24_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;
  logic      done;
  out_item_t out_item;
  int        fail_count;
  int        pending;
  int        burst_left = 0;

  always #5 clk = ~clk;

  float32_to_int24_packer_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .out_item(out_item)
  );

  pcm24_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .out_item(out_item),
    .fail_count(fail_count), .pending(pending)
  );

  // sample values biased toward the interesting exponent window
  function automatic logic [31:0] rand_sample();
    logic [31:0] b;
    b = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: b[30:23] = 8'($urandom_range(110, 127));
      5: b[30:23] = 8'($urandom_range(85, 110));
      6: b[30:23] = 8'hFF;
      7: b[30:23] = 8'h00;
      8: b[30:23] = 8'($urandom_range(126, 128));
      default: ;
    endcase
    return b;
  endfunction

  // one item, held until accepted, with burst-shaped gaps around it
  task automatic send_sample(logic [31:0] bits, logic last);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end
    start <= 1'b1;
    in_item.sample_bits <= bits;
    in_item.last_in <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_order(logic v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  logic [31:0] directed_vals[] = '{
    32'h00000000, 32'h80000000, 32'h00000001, 32'h807FFFFF, 32'h3F800000,
    32'hBF800000, 32'h7F800000, 32'hFF800000, 32'h7FC00000, 32'hFFC00001,
    32'h3F000000, 32'hBF000000, 32'h34000000, 32'hB4000000, 32'h33FFFFFF,
    32'hB4000001, 32'h3F7FFFFF, 32'hBF7FFFFF, 32'h7F7FFFFF, 32'hFFFFFFFF,
    32'h2B800000, 32'hAB800000
  };

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (directed_vals[i]) send_sample(directed_vals[i], 1'(i % 2));
    drain();
    set_order(1'b0);
    foreach (directed_vals[i]) send_sample(directed_vals[i], 1'(i % 3 == 0));
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      set_order(ph == 3 ? 1'b0 : 1'(ph % 2));
      for (int k = 0; k < 250; k++) send_sample(rand_sample(), 1'($urandom_range(0, 1)));
      drain();
    end
    if (fail_count == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: errors");
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
sv/f2i24_pkg.sv
sv/f2i24_convert.sv
sv/float32_to_int24_packer_unit.sv
sv/f2i24_checker.sv
test/pcm24_checker.sv
test/tb.sv
